/* sv/lz77_byte_decompressor_assert.svh */
// Assertion macros shared by the decompressor RTL.
// Each macro expects clk and rst_n in scope.
`ifndef LZ77_BYTE_DECOMPRESSOR_ASSERT_SVH
`define LZ77_BYTE_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define LZD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzd: same-cycle check failed");

// Next-cycle implication, masked while reset is held.
`define LZD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzd: next-cycle check failed");

`endif

/* sv/lzd_pkg.sv */
`timescale 1ns / 1ps

package lzd_pkg;

  // Command kinds passed from the parser to the copy engine
  localparam logic [1:0] CMD_LIT   = 2'd0;
  localparam logic [1:0] CMD_COPY  = 2'd1;
  localparam logic [1:0] CMD_EMPTY = 2'd2;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PW    = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_LW    = $clog2(CMD_DEPTH + 1);

  localparam logic [4:0] LEN_BIAS        = 5'd3;
  localparam logic [3:0] TOKENS_PER_FLAG = 4'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  lit_byte;
    logic        last;      // literal: final byte; copy: final byte of copy ends stream
    logic [11:0] dist_m1;   // displacement minus one
    logic [4:0]  len;       // copy length, 3..18
    logic [4:0]  in_len;    // bytes of the copy that lie within the declared size
  } cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [CMD_LW-1:0] level;
  } fifo_stat_t;

endpackage

/* sv/lzd_front.sv */
`timescale 1ns / 1ps

module lzd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] in_byte
  input  logic          in_tuser,   // [0] start_req
  input  logic          fifo_full,
  output logic          cmd_push,
  output lzd_pkg::cmd_t cmd_data
);

  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [3:0]  tok_r, tok_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic        pend_r, pend_nxt;
  logic        act_r, act_nxt;

  logic        acc;
  logic [4:0]  blk_len;
  logic        rem_ge_len;
  logic [23:0] rem_cpy;
  logic [23:0] rem_lit;

  assign in_tready  = !fifo_full;
  assign acc        = in_tvalid && in_tready;
  assign blk_len    = {1'b0, hi_r[7:4]} + lzd_pkg::LEN_BIAS;
  assign rem_ge_len = rem_r >= {19'b0, blk_len};
  assign rem_cpy    = rem_ge_len ? (rem_r - {19'b0, blk_len}) : 24'd0;
  assign rem_lit    = rem_r - 24'd1;

  always_comb begin
    hdr_cnt_nxt = hdr_cnt_r;
    rem_nxt     = rem_r;
    flag_nxt    = flag_r;
    tok_nxt     = tok_r;
    hi_nxt      = hi_r;
    pend_nxt    = pend_r;
    act_nxt     = act_r;
    cmd_push    = 1'b0;
    cmd_data    = '0;
    if (acc) begin
      if (in_tuser) begin
        hdr_cnt_nxt = 2'd1;
        rem_nxt     = '0;
        flag_nxt    = '0;
        tok_nxt     = '0;
        hi_nxt      = '0;
        pend_nxt    = 1'b0;
        act_nxt     = 1'b1;
      end else if (act_r) begin
        if (hdr_cnt_r != 2'd0) begin
          case (hdr_cnt_r)
            2'd1:    rem_nxt[7:0]   = in_tdata;
            2'd2:    rem_nxt[15:8]  = in_tdata;
            2'd3:    rem_nxt[23:16] = in_tdata;
            default: rem_nxt        = rem_r;
          endcase
          if (hdr_cnt_r == 2'd3) begin
            hdr_cnt_nxt = 2'd0;
            if ({in_tdata, rem_r[15:0]} == 24'd0) begin
              act_nxt       = 1'b0;
              cmd_push      = 1'b1;
              cmd_data.kind = lzd_pkg::CMD_EMPTY;
              cmd_data.last = 1'b1;
            end
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          end
        end else if (tok_r == 4'd0) begin
          flag_nxt = in_tdata;
          tok_nxt  = lzd_pkg::TOKENS_PER_FLAG;
        end else if (flag_r[7]) begin
          if (!pend_r) begin
            hi_nxt   = in_tdata;
            pend_nxt = 1'b1;
          end else begin
            pend_nxt         = 1'b0;
            cmd_push         = 1'b1;
            cmd_data.kind    = lzd_pkg::CMD_COPY;
            cmd_data.dist_m1 = {hi_r[3:0], in_tdata};
            cmd_data.len     = blk_len;
            cmd_data.in_len  = rem_ge_len ? blk_len : rem_r[4:0];
            cmd_data.last    = rem_r <= {19'b0, blk_len};
            rem_nxt          = rem_cpy;
            flag_nxt         = {flag_r[6:0], 1'b0};
            tok_nxt          = tok_r - 4'd1;
            if (rem_cpy == 24'd0) begin
              act_nxt = 1'b0;
            end
          end
        end else begin
          cmd_push          = 1'b1;
          cmd_data.kind     = lzd_pkg::CMD_LIT;
          cmd_data.lit_byte = in_tdata;
          cmd_data.last     = rem_lit == 24'd0;
          rem_nxt           = rem_lit;
          flag_nxt          = {flag_r[6:0], 1'b0};
          tok_nxt           = tok_r - 4'd1;
          if (rem_lit == 24'd0) begin
            act_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r <= '0;
      rem_r     <= '0;
      flag_r    <= '0;
      tok_r     <= '0;
      hi_r      <= '0;
      pend_r    <= 1'b0;
      act_r     <= 1'b0;
    end else begin
      hdr_cnt_r <= hdr_cnt_nxt;
      rem_r     <= rem_nxt;
      flag_r    <= flag_nxt;
      tok_r     <= tok_nxt;
      hi_r      <= hi_nxt;
      pend_r    <= pend_nxt;
      act_r     <= act_nxt;
    end
  end

endmodule

/* sv/lzd_cmd_fifo.sv */
`timescale 1ns / 1ps

module lzd_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lzd_pkg::cmd_t       push_data,
  input  logic                pop,
  output lzd_pkg::cmd_t       head,
  output lzd_pkg::fifo_stat_t stat
);

  lzd_pkg::cmd_t                 q_r [lzd_pkg::CMD_DEPTH];
  logic [lzd_pkg::CMD_PW-1:0]    wr_r, wr_nxt;
  logic [lzd_pkg::CMD_PW-1:0]    rd_r, rd_nxt;
  logic [lzd_pkg::CMD_LW-1:0]    cnt_r, cnt_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign stat.full  = cnt_r == lzd_pkg::CMD_LW'(lzd_pkg::CMD_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign stat.level = cnt_r;
  assign head       = q_r[rd_r];

  // drop a push into a full queue and a pop from an empty one
  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* sv/lzd_back.sv */
`timescale 1ns / 1ps

module lzd_back #(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  lzd_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast,
  output logic [1:0]    out_tuser
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PRIME = 2'd1;
  localparam logic [1:0] ST_COPY  = 2'd2;

  logic [1:0]    st_r, st_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW-1:0] dist_r, dist_nxt;
  logic [4:0]    len_r, len_nxt;
  logic [4:0]    inlen_r, inlen_nxt;
  logic          lastf_r, lastf_nxt;
  logic [4:0]    k_r, k_nxt;

  logic          ov_r;
  logic [7:0]    od_r;
  logic          ol_r;
  logic [1:0]    ou_r;

  logic [7:0]    hist_r [WINDOW_DEPTH];
  logic [7:0]    rdata_r;
  logic          byp_r;
  logic [7:0]    bypd_r;

  logic          can_load;
  logic          load;
  logic [7:0]    ld_data;
  logic          ld_last;
  logic [1:0]    ld_user;
  logic          we;
  logic [7:0]    wdata;
  logic [AW-1:0] rd_addr;
  logic [7:0]    cur;
  logic          k_end;

  assign can_load   = !ov_r || out_tready;
  assign cur        = byp_r ? bypd_r : rdata_r;
  assign k_end      = k_r == (len_r - 5'd1);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = ou_r;

  always_comb begin
    st_nxt    = st_r;
    wp_nxt    = wp_r;
    dist_nxt  = dist_r;
    len_nxt   = len_r;
    inlen_nxt = inlen_r;
    lastf_nxt = lastf_r;
    k_nxt     = k_r;
    cmd_pop   = 1'b0;
    load      = 1'b0;
    ld_data   = '0;
    ld_last   = 1'b0;
    ld_user   = '0;
    we        = 1'b0;
    wdata     = '0;
    rd_addr   = rp_r;
    case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            lzd_pkg::CMD_LIT: begin
              if (can_load) begin
                cmd_pop = 1'b1;
                load    = 1'b1;
                ld_data = cmd.lit_byte;
                ld_last = cmd.last;
                we      = 1'b1;
                wdata   = cmd.lit_byte;
                wp_nxt  = wp_r + 1'b1;
              end
            end
            lzd_pkg::CMD_COPY: begin
              cmd_pop   = 1'b1;
              dist_nxt  = AW'(cmd.dist_m1);
              len_nxt   = cmd.len;
              inlen_nxt = cmd.in_len;
              lastf_nxt = cmd.last;
              k_nxt     = '0;
              st_nxt    = ST_PRIME;
            end
            lzd_pkg::CMD_EMPTY: begin
              if (can_load) begin
                cmd_pop = 1'b1;
                load    = 1'b1;
                ld_last = 1'b1;
                ld_user = 2'b10;
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_PRIME: begin
        // issue the read for the first byte of the copy
        rd_addr = wp_r - dist_r - 1'b1;
        st_nxt  = ST_COPY;
      end
      ST_COPY: begin
        if (can_load) begin
          load    = 1'b1;
          ld_data = cur;
          ld_last = lastf_r && k_end;
          ld_user = {1'b0, k_r >= inlen_r};
          we      = 1'b1;
          wdata   = cur;
          wp_nxt  = wp_r + 1'b1;
          k_nxt   = k_r + 5'd1;
          rd_addr = rp_r + 1'b1;
          if (k_end) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    rp_nxt = rd_addr;
  end

  // history window; a read of the address written in the same cycle takes the new byte
  always_ff @(posedge clk) begin
    if (we) begin
      hist_r[wp_r] <= wdata;
    end
    rdata_r <= hist_r[rd_addr];
    byp_r   <= we && (wp_r == rd_addr);
    bypd_r  <= wdata;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      od_r <= ld_data;
      ol_r <= ld_last;
      ou_r <= ld_user;
    end
    dist_r  <= dist_nxt;
    len_r   <= len_nxt;
    inlen_r <= inlen_nxt;
    lastf_r <= lastf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      wp_r <= '0;
      rp_r <= '0;
      k_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      k_r  <= k_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule

/* sv/lz77_byte_decompressor.sv */
`timescale 1ns / 1ps
// Channel  Ports            tdata          tuser                      tlast
// in       in_t*            [7:0] in_byte  [0] start_req              -
// out      out_t*           [7:0] out_byte [0] past_size [1] empty_res last
//
// The parser takes one compressed byte per cycle while its command queue has room.
// A literal or an empty-stream result goes straight to the output register; a copy of
// length L (3..18) sends one byte a cycle from the history port while not stalled.
// Reset clears the control state; the history window is not cleared.
// The queue lets the input side run on while the output side is stalled.
`include "lz77_byte_decompressor_assert.svh"

module lz77_byte_decompressor #(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] start_req
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [0] past_size, [1] empty_res
);

  logic                cmd_push;
  lzd_pkg::cmd_t       cmd_in;
  lzd_pkg::cmd_t       cmd_head;
  logic                cmd_pop;
  lzd_pkg::fifo_stat_t fifo_st;

  lzd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fifo_full (fifo_st.full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in)
  );

  lzd_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .pop       (cmd_pop),
    .head      (cmd_head),
    .stat      (fifo_st)
  );

  lzd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (!fifo_st.empty),
    .cmd        (cmd_head),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `LZD_ASSERT_IMP(a_level_bound, 1'b1, fifo_st.level <= lzd_pkg::CMD_LW'(lzd_pkg::CMD_DEPTH))
  `LZD_ASSERT_IMP(a_empty_marks, out_tvalid && out_tuser[1], out_tlast && !out_tuser[0])
  `LZD_ASSERT_NXT(a_drain_empty, cmd_pop && !cmd_push && fifo_st.level == 1, fifo_st.empty)

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stim_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       past;
    logic       empty;
  } lz_out_t;

  // Byte-level LZ10 decoder: holds its own window and parser state.
  class lz10_board;
    logic [7:0]  window [4096];
    int unsigned filled;       // bytes written since reset, saturating
    logic [11:0] wr_ptr;
    logic [23:0] remaining;
    int unsigned hdr_idx;      // 0 = header done, 1..3 = next size byte
    logic [7:0]  flags;
    logic [3:0]  tokens_left;
    logic [7:0]  ref_hi;
    bit          ref_pend;
    bit          active;
    lz_out_t     expected_bytes[$];
    int unsigned errors;

    function new();
      filled      = 0;
      wr_ptr      = '0;
      remaining   = '0;
      hdr_idx     = 0;
      flags       = '0;
      tokens_left = '0;
      ref_hi      = '0;
      ref_pend    = 1'b0;
      active      = 1'b0;
      errors      = 0;
    endfunction

    function void write_window(logic [7:0] b);
      window[wr_ptr] = b;
      wr_ptr = wr_ptr + 12'd1;
      if (filled < 4096) filled++;
    endfunction

    function void finish_token();
      flags = flags << 1;
      tokens_left = tokens_left - 4'd1;
      if (remaining == '0) active = 1'b0;
    endfunction

    function void take_byte(logic [7:0] b, logic start);
      logic [15:0] pair;
      logic [11:0] rd_ptr;
      logic [7:0]  v;
      logic        past;
      int unsigned len;
      if (start) begin
        hdr_idx     = 1;
        remaining   = '0;
        flags       = '0;
        tokens_left = '0;
        ref_hi      = '0;
        ref_pend    = 1'b0;
        active      = 1'b1;
        return;
      end
      if (!active) return;
      if (hdr_idx != 0) begin
        remaining[8 * (hdr_idx - 1) +: 8] = b;
        if (hdr_idx == 3) begin
          hdr_idx = 0;
          if (remaining == '0) begin
            active = 1'b0;
            expected_bytes.push_back('{8'h00, 1'b1, 1'b0, 1'b1});
          end
        end else begin
          hdr_idx++;
        end
        return;
      end
      if (tokens_left == '0) begin
        flags = b;
        tokens_left = 4'd8;
        return;
      end
      if (flags[7]) begin
        if (!ref_pend) begin
          ref_hi = b;
          ref_pend = 1'b1;
          return;
        end
        ref_pend = 1'b0;
        pair = {ref_hi, b};
        len = pair[15:12] + 3;
        for (int k = 0; k < len; k++) begin
          rd_ptr = wr_ptr - pair[11:0] - 12'd1;
          v = window[rd_ptr];
          past = (remaining == '0);
          if (!past) remaining = remaining - 24'd1;
          write_window(v);
          expected_bytes.push_back('{v, (k == len - 1) && (remaining == '0), past, 1'b0});
        end
        finish_token();
        return;
      end
      write_window(b);
      remaining = remaining - 24'd1;
      expected_bytes.push_back('{b, remaining == '0, 1'b0, 1'b0});
      finish_token();
    endfunction

    function void check_byte(lz_out_t got);
      lz_out_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected output, expected none, got data %02h last %0b past %0b empty %0b",
                 $time, got.data, got.last, got.past, got.empty);
        return;
      end
      want = expected_bytes.pop_front();
      // out_byte carries nothing on an empty-stream result
      if (!want.empty && got.data !== want.data) begin
        errors++;
        $display("%0t: out_byte mismatch, expected %02h, got %02h", $time, want.data, got.data);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, got.last);
      end
      if (got.past !== want.past) begin
        errors++;
        $display("%0t: past_size mismatch, expected %0b, got %0b", $time, want.past, got.past);
      end
      if (got.empty !== want.empty) begin
        errors++;
        $display("%0t: empty_res mismatch, expected %0b, got %0b", $time, want.empty, got.empty);
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic       in_tuser   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [1:0] out_tuser;

  lz10_board   board;
  lz10_board   shadow;      // tracks the stream as it is built
  stim_t       stim_q[$];
  int unsigned gen_count;
  logic [7:0]  ref_lo;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_req = 0;

  lz77_byte_decompressor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.take_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready)
        board.check_byte('{out_tdata, out_tlast, out_tuser[0], out_tuser[1]});
    end
  end

  // Receiver: random backpressure, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic void put_byte(logic [7:0] b, logic start);
    stim_q.push_back('{b, start});
    shadow.take_byte(b, start);
    shadow.expected_bytes.delete();
  endfunction

  function automatic void directed_items();
    put_byte(8'hFF, 1'b0);                       // idle input, ignored
    put_byte(8'h00, 1'b1);                       // zero-size stream
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b1);                       // size 20: literal, longest copy, literal
    put_byte(8'h14, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h40, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hF0, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h5A, 1'b1);                       // size 2, copy of 3 runs past it
    put_byte(8'h02, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h80, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h02, 1'b0);
    put_byte(8'h33, 1'b1);                       // cut short by the next start
    put_byte(8'h10, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h7E, 1'b0);
  endfunction

  // One stream; distances never reach past what the window holds.
  function automatic void gen_stream();
    int unsigned size, roll, cut, n, avail, dist_m1;
    logic [7:0]  b;
    roll = $urandom_range(99);
    if (roll < 6) size = 0;
    else if (roll < 12) size = $urandom_range(24'hFFFFFF, 24'h000100);
    else if (roll < 20) size = $urandom_range(200, 61);
    else size = $urandom_range(40, 1);
    // huge sizes never finish, so cut them with a restart
    cut = ((roll >= 6 && roll < 12) || $urandom_range(99) < 10) ? $urandom_range(30, 1) : 0;
    put_byte(8'($urandom_range(255)), 1'b1);
    n = 1;
    while (shadow.active && (cut == 0 || n < cut)) begin
      if (shadow.hdr_idx != 0) begin
        b = 8'(size >> (8 * (shadow.hdr_idx - 1)));
      end else if (shadow.tokens_left == '0) begin
        b = 8'($urandom_range(255));
        if (shadow.filled == 0) b[7] = 1'b0;
      end else if (shadow.ref_pend) begin
        b = ref_lo;
      end else if (shadow.flags[7]) begin
        avail = shadow.filled;
        if ($urandom_range(1)) dist_m1 = $urandom_range(avail < 16 ? avail - 1 : 15, 0);
        else dist_m1 = $urandom_range(avail - 1, 0);
        b = {4'($urandom_range(15)), 4'(dist_m1 >> 8)};
        ref_lo = 8'(dist_m1);
      end else begin
        b = 8'($urandom_range(255));
      end
      put_byte(b, 1'b0);
      n++;
    end
    gen_count += n;
  endfunction

  function automatic void gen_items(int unsigned target);
    gen_count = 0;
    while (gen_count < target) begin
      if (!shadow.active && $urandom_range(99) < 10) put_byte(8'($urandom_range(255)), 1'b0);
      gen_stream();
    end
  endfunction

  task automatic send_item(stim_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s.data;
    in_tuser  <= s.start;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_stim();
    while (stim_q.size() != 0) send_item(stim_q.pop_front());
  endtask

  // let the monitor log the last accepted transaction before looking at the queue
  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.expected_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    board  = new();
    shadow = new();
    tx_idle_pct = 12;
    rx_idle_pct = 61;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    drain_stim();
    gen_items(35);
    drain_stim();
    // stall the output while input keeps coming
    hold_req = 400;
    gen_items(35);
    drain_stim();
    pause_until_drained();
    tx_idle_pct = 61;
    rx_idle_pct = 12;
    gen_items(65);
    drain_stim();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    gen_items(65);
    drain_stim();
    pause_until_drained();
    repeat (64) @(posedge clk);
    if (board.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
